// ===== hdl/tstm_pkg.sv =====
package tstm_pkg;

   localparam logic [15:0] RPM_LIMIT = 16'd20000;
   localparam logic [15:0] TORQUE_LIMIT = 16'd4000;

   localparam int DivStages = 8;
   localparam int BitsPerStage = 2;
   localparam int PipeDepth = DivStages + 2;

   localparam logic [1:0] DIR_NEUTRAL = 2'd0;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   typedef enum logic [3:0] {
      REG_VOLT_MIN         = 4'd0,
      REG_VOLT_MAX         = 4'd1,
      REG_SPEED_CAP_ECO    = 4'd2,
      REG_SPEED_CAP_SPORT  = 4'd3,
      REG_SPEED_CAP_BACK   = 4'd4,
      REG_TORQUE_CAP_ECO   = 4'd5,
      REG_TORQUE_CAP_SPORT = 4'd6,
      REG_TORQUE_CAP_BACK  = 4'd7
   } reg_index_type;

   localparam logic [15:0] VOLT_MIN_RESET = 16'd500;
   localparam logic [15:0] VOLT_MAX_RESET = 16'd4500;
   localparam logic [15:0] SPEED_ECO_RESET = 16'd3000;
   localparam logic [15:0] SPEED_SPORT_RESET = 16'd6000;
   localparam logic [15:0] SPEED_BACK_RESET = 16'd1000;
   localparam logic [15:0] TORQUE_ECO_RESET = 16'd800;
   localparam logic [15:0] TORQUE_SPORT_RESET = 16'd1600;
   localparam logic [15:0] TORQUE_BACK_RESET = 16'd480;

   typedef struct packed {
      logic [15:0] throttle_mv;
      logic [1:0]  travel_dir;
      logic        sport_mode;
      logic [15:0] motor_torque_limit;
   } req_type;

   typedef struct packed {
      logic [15:0] target_rpm;
      logic [15:0] torque_ref;
   } rsp_type;

   function automatic logic [15:0] sat16(input logic [15:0] value, input logic [15:0] limit);
      return (value > limit) ? limit : value;
   endfunction

endpackage

// ===== hdl/throttle_to_speed_torque_map_top.sv =====
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | tstm_pkg::req_type
// rsp     | out       | rsp_valid / rsp_ready  | tstm_pkg::rsp_type
// csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// One beat is accepted every cycle while req_ready is high; each result passes through
// ten register stages: window and cap selection, the two multipliers, then eight
// divider stages that each resolve two quotient bits.
// Synchronous reset clears the valid bits and loads the register reset values.
// Each stage holds its beat only while the stage after it is full and stalled,
// so bubbles close up and input is taken while a finished result waits.
module throttle_to_speed_torque_map_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tstm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tstm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import tstm_pkg::*;

   typedef struct packed {
      logic        zero;
      logic [15:0] dvs;
      logic [15:0] span;
      logic [15:0] rpm_cap;
      logic [15:0] trq_cap;
   } sel_type;

   typedef struct packed {
      logic        zero;
      logic [15:0] dvs;
      logic [15:0] rpm_rem;
      logic [15:0] rpm_low;
      logic [15:0] trq_rem;
      logic [15:0] trq_low;
   } div_type;

   logic [15:0] volt_min_ff, volt_max_ff;
   logic [15:0] speed_eco_ff, speed_sport_ff, speed_back_ff;
   logic [15:0] torque_eco_ff, torque_sport_ff, torque_back_ff;

   logic [PipeDepth-1:0] valid_ff;
   logic [PipeDepth-1:0] valid_in;
   logic [PipeDepth-1:0] stage_ready;

   sel_type sel_ff, sel_in;
   div_type div_ff [DivStages+1];
   div_type div_in [DivStages+1];

   function automatic logic [31:0] div_step(input logic [15:0] rem, input logic [15:0] low,
                                            input logic [15:0] dvs);
      logic [16:0] trial;
      logic [16:0] diff;
      logic        take;
      trial = {rem, low[15]};
      diff = trial - {1'b0, dvs};
      take = (trial >= {1'b0, dvs});
      return {(take ? diff[15:0] : trial[15:0]), low[14:0], take};
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_min_ff     <= VOLT_MIN_RESET;
         volt_max_ff     <= VOLT_MAX_RESET;
         speed_eco_ff    <= sat16(SPEED_ECO_RESET, RPM_LIMIT);
         speed_sport_ff  <= sat16(SPEED_SPORT_RESET, RPM_LIMIT);
         speed_back_ff   <= sat16(SPEED_BACK_RESET, RPM_LIMIT);
         torque_eco_ff   <= sat16(TORQUE_ECO_RESET, TORQUE_LIMIT);
         torque_sport_ff <= sat16(TORQUE_SPORT_RESET, TORQUE_LIMIT);
         torque_back_ff  <= sat16(TORQUE_BACK_RESET, TORQUE_LIMIT);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_VOLT_MIN:         volt_min_ff <= csr_data;
            REG_VOLT_MAX:         volt_max_ff <= csr_data;
            REG_SPEED_CAP_ECO:    speed_eco_ff <= sat16(csr_data, RPM_LIMIT);
            REG_SPEED_CAP_SPORT:  speed_sport_ff <= sat16(csr_data, RPM_LIMIT);
            REG_SPEED_CAP_BACK:   speed_back_ff <= sat16(csr_data, RPM_LIMIT);
            REG_TORQUE_CAP_ECO:   torque_eco_ff <= sat16(csr_data, TORQUE_LIMIT);
            REG_TORQUE_CAP_SPORT: torque_sport_ff <= sat16(csr_data, TORQUE_LIMIT);
            REG_TORQUE_CAP_BACK:  torque_back_ff <= sat16(csr_data, TORQUE_LIMIT);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      stage_ready[PipeDepth-1] = !valid_ff[PipeDepth-1] || rsp_ready;
      for (int k = PipeDepth - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < PipeDepth; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_ready = stage_ready[0];

   always_ff @(posedge clock) begin
      for (int k = 0; k < PipeDepth; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (stage_ready[k]) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_comb begin
      logic [15:0] clamped;
      logic [15:0] rpm_cap;
      logic [15:0] trq_cap;
      clamped = (req_data.throttle_mv > volt_max_ff) ? volt_max_ff : req_data.throttle_mv;
      if (req_data.travel_dir == DIR_NEUTRAL) begin
         rpm_cap = '0;
         trq_cap = '0;
      end else if (req_data.travel_dir == DIR_REVERSE) begin
         rpm_cap = speed_back_ff;
         trq_cap = torque_back_ff;
      end else begin
         rpm_cap = req_data.sport_mode ? speed_sport_ff : speed_eco_ff;
         trq_cap = req_data.sport_mode ? torque_sport_ff : torque_eco_ff;
      end
      sel_in.zero = (volt_max_ff <= volt_min_ff);
      sel_in.dvs = volt_max_ff - volt_min_ff;
      sel_in.span = (clamped > volt_min_ff) ? clamped - volt_min_ff : '0;
      sel_in.rpm_cap = rpm_cap;
      sel_in.trq_cap = (req_data.motor_torque_limit < trq_cap) ?
                       req_data.motor_torque_limit : trq_cap;
   end

   always_comb begin
      logic [31:0] rpm_num;
      logic [31:0] trq_num;
      logic [31:0] step;
      div_type     cur;
      rpm_num = {16'd0, sel_ff.span} * {16'd0, sel_ff.rpm_cap};
      trq_num = {16'd0, sel_ff.span} * {16'd0, sel_ff.trq_cap};
      div_in[0].zero = sel_ff.zero;
      div_in[0].dvs = sel_ff.dvs;
      div_in[0].rpm_rem = rpm_num[31:16];
      div_in[0].rpm_low = rpm_num[15:0];
      div_in[0].trq_rem = trq_num[31:16];
      div_in[0].trq_low = trq_num[15:0];
      for (int s = 1; s <= DivStages; s++) begin
         cur = div_ff[s-1];
         for (int b = 0; b < BitsPerStage; b++) begin
            step = div_step(cur.rpm_rem, cur.rpm_low, cur.dvs);
            cur.rpm_rem = step[31:16];
            cur.rpm_low = step[15:0];
            step = div_step(cur.trq_rem, cur.trq_low, cur.dvs);
            cur.trq_rem = step[31:16];
            cur.trq_low = step[15:0];
         end
         div_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         sel_ff <= sel_in;
      end
      for (int s = 0; s <= DivStages; s++) begin
         if (stage_ready[s+1]) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   assign rsp_valid = valid_ff[PipeDepth-1];
   assign rsp_data.target_rpm = div_ff[DivStages].zero ? '0 : div_ff[DivStages].rpm_low;
   assign rsp_data.torque_ref = div_ff[DivStages].zero ? '0 : div_ff[DivStages].trq_low;

endmodule

// ===== hdl/tstm_checker.sv =====
module tstm_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tstm_pkg::rsp_type rsp_data
);
   import tstm_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat dropped or changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.target_rpm <= RPM_LIMIT)
      else $error("target speed above the RPM limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.torque_ref <= TORQUE_LIMIT)
      else $error("torque reference above the torque limit");

endmodule

bind throttle_to_speed_torque_map_top tstm_checker u_tstm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
